[hdl/spimb_pkg.sv]
package spimb_pkg;

  localparam int DATA_BITS = 8;
  localparam int HALF_LOG2_MAX = 6;
  localparam int HALF_CNT_W = HALF_LOG2_MAX;
  localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);
  localparam int CFG_DATA_W = 3;

  typedef enum logic [1:0] {
    CFG_MSB_LEAD   = 2'd0,
    CFG_POLARITY   = 2'd1,
    CFG_PHASE      = 2'd2,
    CFG_HALF_LOG2  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                 req_type;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 miso_level;
  } req_t;

  typedef struct packed {
    logic                 sck_level;
    logic                 mosi_level;
    logic                 busy_res;
    logic                 rx_valid;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 start_rejected;
  } res_t;

endpackage

[hdl/spi_master_byte_shifter_core.sv]
// SPI master byte shifter, modes 0 to 3.
// Request channel (req_valid, req_stall, req_data): each transfer is either one
// time tick or a start request carrying the byte to send; the sampled MISO
// level rides along with every tick.
// Result channel (res_valid, res_stall, res_data): exactly one result per
// request, giving the SCK and MOSI pin levels, busy, the received byte on the
// tick that ends a byte, and a flag for a start that arrived while busy.
// Throughput is one request per cycle while req_stall is low; the state update
// is a single pass of logic between the state registers and the result
// register. A two-entry output buffer decouples the sides: while the receiver
// stalls, one more request is taken into the skid stage, after which req_stall
// rises. The user must write the configuration through cfg_write, cfg_index
// and cfg_data only while idle; the block does not enforce this. Reset clears
// the buffer, leaves the shifter idle with SCK low and MOSI low, and restores
// MSB-first, mode 0 and the shortest divider.
module spi_master_byte_shifter_core
  import spimb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res_data,
  input  logic                  cfg_write,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic accept;
  res_t step_res;

  assign accept = req_valid && !req_stall;

  spimb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (step_res)
  );

  spimb_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_data  (step_res),
    .push_stall (req_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.rx_valid |-> !res_data.busy_res)
    else $error("byte completed while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.start_rejected |-> res_data.busy_res)
    else $error("start rejected while idle");

  a_idle_mosi_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.busy_res |-> !res_data.mosi_level)
    else $error("MOSI not low while idle");
`endif

endmodule

[hdl/spimb_engine.sv]
module spimb_engine
  import spimb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  req_t                  req,
  input  logic                  cfg_write,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output res_t                  res
);

  // Configuration registers.
  logic       msb_lead;
  logic       clock_polarity;
  logic       clock_phase;
  logic [2:0] half_period_log2;

  // Transfer state.
  logic [DATA_BITS-1:0]  tx_shift;
  logic [DATA_BITS-1:0]  rx_shift;
  logic [BIT_CNT_W-1:0]  bits_done;
  logic [1:0]            bit_phase;
  logic [HALF_CNT_W-1:0] half_counter;
  logic                  active;
  logic                  sck;
  logic                  mosi;

  logic [DATA_BITS-1:0]  tx_shift_next;
  logic [DATA_BITS-1:0]  rx_shift_next;
  logic [BIT_CNT_W-1:0]  bits_done_next;
  logic [1:0]            bit_phase_next;
  logic [HALF_CNT_W-1:0] half_counter_next;
  logic                  active_next;
  logic                  sck_next;
  logic                  mosi_next;

  logic [2:0]            half_log2_sat;
  logic [HALF_CNT_W-1:0] half_last;
  logic [1:0]            halves;
  logic [1:0]            phase_inc;
  logic [BIT_CNT_W-1:0]  bits_inc;
  logic [DATA_BITS-1:0]  tx_src;
  logic                  load_bit;
  logic                  done;
  logic                  rejected;

  assign half_log2_sat = (half_period_log2 > 3'(HALF_LOG2_MAX)) ?
                         3'(HALF_LOG2_MAX) : half_period_log2;
  assign half_last = HALF_CNT_W'(((HALF_CNT_W + 1)'(1) << half_log2_sat)
                                 - (HALF_CNT_W + 1)'(1));
  assign halves    = clock_phase ? 2'd2 : 2'd3;
  assign phase_inc = bit_phase + 2'd1;
  assign bits_inc  = bits_done + BIT_CNT_W'(1);

  always_comb begin
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    bits_done_next    = bits_done;
    bit_phase_next    = bit_phase;
    half_counter_next = half_counter;
    active_next       = active;
    sck_next          = sck;
    mosi_next         = mosi;
    tx_src            = tx_shift;
    load_bit          = 1'b0;
    done              = 1'b0;
    rejected          = 1'b0;

    if (req.req_type) begin
      if (active) begin
        rejected = 1'b1;
      end else begin
        tx_src            = req.tx_byte;
        rx_shift_next     = '0;
        bits_done_next    = '0;
        half_counter_next = '0;
        active_next       = 1'b1;
        load_bit          = 1'b1;
      end
    end else if (active) begin
      if (half_counter >= half_last) begin
        half_counter_next = '0;
        // MISO is sampled at the end of the second half of a bit.
        if (bit_phase == 2'd1) begin
          rx_shift_next = msb_lead ? {rx_shift[DATA_BITS-2:0], req.miso_level}
                                   : {req.miso_level, rx_shift[DATA_BITS-1:1]};
        end
        if (phase_inc < halves) begin
          bit_phase_next = phase_inc;
          sck_next = (!clock_phase && phase_inc == 2'd1) ? ~clock_polarity
                                                          : clock_polarity;
        end else begin
          sck_next       = clock_polarity;
          bits_done_next = bits_inc;
          if (bits_inc >= BIT_CNT_W'(DATA_BITS)) begin
            active_next    = 1'b0;
            bit_phase_next = 2'd0;
            mosi_next      = 1'b0;
            done           = 1'b1;
          end else begin
            load_bit = 1'b1;
          end
        end
      end else begin
        half_counter_next = half_counter + HALF_CNT_W'(1);
      end
    end

    // Start of a new bit: present it on MOSI, and with phase 1 raise the
    // leading clock edge together with it.
    if (load_bit) begin
      bit_phase_next = 2'd0;
      if (clock_phase) begin
        sck_next = ~clock_polarity;
      end
      mosi_next     = msb_lead ? tx_src[DATA_BITS-1] : tx_src[0];
      tx_shift_next = msb_lead ? {tx_src[DATA_BITS-2:0], 1'b0}
                               : {1'b0, tx_src[DATA_BITS-1:1]};
    end
  end

  always_comb begin
    res.sck_level      = sck_next;
    res.mosi_level     = mosi_next;
    res.busy_res       = active_next;
    res.rx_valid       = done;
    res.rx_byte        = done ? rx_shift_next : '0;
    res.start_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_lead         <= 1'b1;
      clock_polarity   <= 1'b0;
      clock_phase      <= 1'b0;
      half_period_log2 <= '0;
      tx_shift         <= '0;
      rx_shift         <= '0;
      bits_done        <= '0;
      bit_phase        <= '0;
      half_counter     <= '0;
      active           <= 1'b0;
      sck              <= 1'b0;
      mosi             <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MSB_LEAD:  msb_lead         <= cfg_data[0];
          CFG_POLARITY:  clock_polarity   <= cfg_data[0];
          CFG_PHASE:     clock_phase      <= cfg_data[0];
          CFG_HALF_LOG2: half_period_log2 <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        tx_shift     <= tx_shift_next;
        rx_shift     <= rx_shift_next;
        bits_done    <= bits_done_next;
        bit_phase    <= bit_phase_next;
        half_counter <= half_counter_next;
        active       <= active_next;
        mosi         <= mosi_next;
      end
      // While idle the clock pin follows a polarity write at once.
      if (cfg_write && cfg_index == CFG_POLARITY && !active) begin
        sck <= cfg_data[0];
      end else if (accept) begin
        sck <= sck_next;
      end
    end
  end

endmodule

[hdl/spimb_outbuf.sv]
module spimb_outbuf
  import spimb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  res_t push_data,
  output logic push_stall,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  logic main_valid;
  res_t main_reg;
  logic skid_valid;
  res_t skid_reg;
  logic push;
  logic take;

  assign push       = push_valid && !skid_valid;
  assign take       = main_valid && !res_stall;
  assign push_stall = skid_valid;
  assign res_valid  = main_valid;
  assign res_data   = main_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!main_valid || take) begin
      main_reg <= skid_valid ? skid_reg : push_data;
    end else if (push) begin
      skid_reg <= push_data;
    end
  end

endmodule
